>>> hdl/teactr_pkg.sv
// ----------------------------------------------------------------------------
// teactr_pkg
// Types and constants shared by the counter-mode TEA cipher and its rounds.
// ----------------------------------------------------------------------------
`default_nettype none

package teactr_pkg;

  // TEA round constant
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_NONCE = 3'd4;

  // Input beat
  typedef struct packed {
    logic [31:0] block_index;
    logic [63:0] data_block;
    logic        last_block;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [63:0] result_block;
    logic        last_out;
  } out_t;

  // 128-bit key as four words
  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // One pipeline slot: counter word halves plus the data riding along
  typedef struct packed {
    logic        valid;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [63:0] data;
    logic        last;
  } stage_t;

endpackage : teactr_pkg

`default_nettype wire

>>> hdl/teactr_round.sv
// ----------------------------------------------------------------------------
// teactr_round
// One TEA round as two register stages, one per half-round.
// ----------------------------------------------------------------------------
`default_nettype none

module teactr_round #(
  parameter logic [31:0] SUM = 32'h9E37_79B9
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire teactr_pkg::key_t    key,
  input  wire teactr_pkg::stage_t  stage_in,
  output teactr_pkg::stage_t       stage_out
);
  import teactr_pkg::*;

  stage_t half_r;
  stage_t half_nxt;
  stage_t out_r;
  stage_t out_nxt;

  // TEA mixing function for one half
  function automatic logic [31:0] mix_half(input logic [31:0] v,
                                           input logic [31:0] ka,
                                           input logic [31:0] kb);
    mix_half = ((v << 4) + ka) ^ (v + SUM) ^ ((v >> 5) + kb);
  endfunction

  // First half-round updates v0 from v1
  always_comb begin
    half_nxt    = stage_in;
    half_nxt.v0 = stage_in.v0 + mix_half(stage_in.v1, key.k0, key.k1);
  end

  // Second half-round updates v1 from the new v0
  always_comb begin
    out_nxt    = half_r;
    out_nxt.v1 = half_r.v1 + mix_half(half_r.v0, key.k2, key.k3);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r.valid <= 1'b0;
      out_r.valid  <= 1'b0;
    end else if (en) begin
      half_r.valid <= half_nxt.valid;
      out_r.valid  <= out_nxt.valid;
    end
  end

  // Advance payload, hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      half_r.v0   <= half_nxt.v0;
      half_r.v1   <= half_nxt.v1;
      half_r.data <= half_nxt.data;
      half_r.last <= half_nxt.last;
      out_r.v0    <= out_nxt.v0;
      out_r.v1    <= out_nxt.v1;
      out_r.data  <= out_nxt.data;
      out_r.last  <= out_nxt.last;
    end
  end

  assign stage_out = out_r;

endmodule : teactr_round

`default_nettype wire

>>> hdl/tea_ctr_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_ctr_block_cipher
// Counter-mode TEA keystream cipher with a fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four key words and the 64-bit nonce through the cfg_ port while
//   the pipeline is empty. Each input beat carries a block index, a 64-bit
//   data block and a last marker. The counter word (index XOR nonce) is
//   enciphered with TEA for ROUNDS rounds and XORed into the data block; the
//   same path encrypts and decrypts. The last marker rides along unchanged.
// Timing:
//   The path holds one input register, one register per half-round and one
//   output register. One beat is taken every cycle unless the pipeline is
//   stalled; the logic between stages is a single half-round.
// Reset:
//   rst_n clears all valid bits and the key and nonce registers to zero.
// Backpressure:
//   While out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall is raised; no beat is lost or repeated. A bubble in the
//   output register lets the pipeline advance even under out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_ctr_block_cipher #(
  parameter int unsigned ROUNDS = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  teactr_pkg::in_t                 in_payload,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output teactr_pkg::out_t                      out_payload,
  // configuration
  input  wire                                   cfg_we,
  input  wire  [teactr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [teactr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import teactr_pkg::*;

  key_t        key_r;
  logic [63:0] nonce_r;
  logic        en;
  stage_t      pipe [0:ROUNDS];
  stage_t      entry_r;
  stage_t      entry_nxt;
  logic        out_valid_r;
  out_t        out_payload_r;
  out_t        out_payload_nxt;

  // Global advance: move unless a waiting result is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD_0:    key_r.k0 <= cfg_data[31:0];
        REG_KEY_WORD_1:    key_r.k1 <= cfg_data[31:0];
        REG_KEY_WORD_2:    key_r.k2 <= cfg_data[31:0];
        REG_KEY_WORD_3:    key_r.k3 <= cfg_data[31:0];
        REG_COUNTER_NONCE: nonce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Form the counter word at entry
  always_comb begin
    entry_nxt.valid = in_valid;
    entry_nxt.v0    = in_payload.block_index ^ nonce_r[31:0];
    entry_nxt.v1    = nonce_r[63:32];
    entry_nxt.data  = in_payload.data_block;
    entry_nxt.last  = in_payload.last_block;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (en) begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r.v0   <= entry_nxt.v0;
      entry_r.v1   <= entry_nxt.v1;
      entry_r.data <= entry_nxt.data;
      entry_r.last <= entry_nxt.last;
    end
  end

  assign pipe[0] = entry_r;

  // Unrolled rounds, each with its own round sum
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    localparam logic [63:0] SUM_WIDE = 64'(TEA_DELTA) * 64'(g + 1);

    teactr_round #(
      .SUM (SUM_WIDE[31:0])
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .key       (key_r),
      .stage_in  (pipe[g]),
      .stage_out (pipe[g+1])
    );
  end

  // Apply keystream into the output register
  always_comb begin
    out_payload_nxt.result_block = pipe[ROUNDS].data ^ {pipe[ROUNDS].v1, pipe[ROUNDS].v0};
    out_payload_nxt.last_out     = pipe[ROUNDS].last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_payload_r <= out_payload_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule : tea_ctr_block_cipher

`default_nettype wire

>>> sim/tea_ctr_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tea_ctr_block_cipher_tb
// Self-checking bench for the counter-mode TEA cipher pipeline.
// A queue of blocks feeds a valid/stall driver. A monitor predicts each
// accepted beat with its own TEA keystream model and checks every result
// beat in order. The bench runs the all-zero reset settings and several key
// and nonce loads, including all ones and writes to unused register slots. It mixes sender and
// receiver idle patterns, and one long receiver hold-off backs the pipe up
// into the input.
// ----------------------------------------------------------------------------

module tea_ctr_block_cipher_tb;

  import teactr_pkg::*;

  localparam int unsigned TEA_ROUNDS   = 1024;
  localparam int unsigned PIPE_LATENCY = 2 * TEA_ROUNDS + 2;
  localparam int unsigned HOLD_CYCLES  = PIPE_LATENCY + 950;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_payload = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_payload;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // mirrored cipher settings
  key_t        cipher_key   = '0;
  logic [63:0] cipher_nonce = '0;

  in_t  block_q[$];
  out_t expected_q[$];

  int unsigned fail_count      = 0;
  int unsigned blocks_sent     = 0;
  int unsigned blocks_checked  = 0;
  int unsigned stall_cycles    = 0;
  int unsigned settings_loaded = 0;
  int unsigned send_idle_pct   = 22;
  int unsigned recv_idle_pct   = 85;
  int unsigned hold_left       = 0;
  bit          in_taken        = 1'b0;
  bit          hold_go         = 1'b0;
  bit          hold_used       = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  tea_ctr_block_cipher #(
    .ROUNDS(TEA_ROUNDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // One TEA half-round mixing term; all sums wrap at 32 bits
  function automatic logic [31:0] tea_mix(logic [31:0] v, logic [31:0] s,
                                          logic [31:0] ka, logic [31:0] kb);
    logic [31:0] shl;
    logic [31:0] shr;
    shl = (v << 4) + ka;
    shr = (v >> 5) + kb;
    return shl ^ (v + s) ^ shr;
  endfunction

  // Encipher index ^ nonce and XOR the keystream word into the data block
  function automatic out_t ctr_cipher_beat(in_t blk);
    logic [63:0] ctr;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    out_t        res;
    ctr = {32'h0, blk.block_index} ^ cipher_nonce;
    y   = ctr[31:0];
    z   = ctr[63:32];
    sum = '0;
    for (int unsigned n = 0; n < TEA_ROUNDS; n++) begin
      sum = sum + TEA_DELTA;
      y   = y + tea_mix(z, sum, cipher_key.k0, cipher_key.k1);
      z   = z + tea_mix(y, sum, cipher_key.k2, cipher_key.k3);
    end
    res.result_block = blk.data_block ^ {z, y};
    res.last_out     = blk.last_block;
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic add_block(logic [31:0] idx, logic [63:0] data, logic last);
    block_q.push_back(in_t'{block_index: idx, data_block: data, last_block: last});
  endtask

  // Mostly well-formed messages (index from zero, last on the final block),
  // with some loose blocks of fully random index and marker mixed in
  task automatic queue_traffic(int unsigned count);
    int unsigned left;
    logic [31:0] pos;
    left = 0;
    pos  = '0;
    repeat (count) begin
      if (left == 0 && $urandom_range(99) < 20) begin
        add_block($urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
      end else begin
        if (left == 0) begin
          left = $urandom_range(16, 1);
          pos  = '0;
        end
        add_block(pos, {$urandom, $urandom}, left == 1);
        pos++;
        left--;
      end
    end
  endtask

  // Write one register and mirror it; unused slots are ignored
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_KEY_WORD_0:    cipher_key.k0 = val[31:0];
      REG_KEY_WORD_1:    cipher_key.k1 = val[31:0];
      REG_KEY_WORD_2:    cipher_key.k2 = val[31:0];
      REG_KEY_WORD_3:    cipher_key.k3 = val[31:0];
      REG_COUNTER_NONCE: cipher_nonce  = val;
      default: ;
    endcase
  endtask

  // Load key and nonce; key writes carry junk in the upper half to be dropped
  task automatic load_settings(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                               logic [31:0] k3, logic [63:0] nonce, bit spares);
    cfg_write(REG_KEY_WORD_0, {$urandom, k0});
    cfg_write(REG_KEY_WORD_1, {$urandom, k1});
    cfg_write(REG_KEY_WORD_2, {$urandom, k2});
    cfg_write(REG_KEY_WORD_3, {$urandom, k3});
    cfg_write(REG_COUNTER_NONCE, nonce);
    if (spares) begin
      for (int i = int'(REG_COUNTER_NONCE) + 1; i < (1 << CFG_IDX_W); i++) begin
        cfg_write(CFG_IDX_W'(i), {$urandom, $urandom});
      end
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Wait until every queued block went in and every result came back
  task automatic drain_pipe();
    @(posedge clk);
    while (block_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Input driver: hold a stalled beat, otherwise offer the next block or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // keep beat and valid steady until taken
    end else if (block_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_payload <= block_q.pop_front();
      in_valid   <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: one long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict accepted input beats, check result beats in order
  always @(posedge clk) begin : beat_check
    out_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_valid && in_stall) begin
        stall_cycles++;
      end
      if (in_taken) begin
        expected_q.push_back(ctr_cipher_beat(in_payload));
        blocks_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing pending", out_payload));
        end else begin
          want = expected_q.pop_front();
          blocks_checked++;
          if (out_payload.result_block !== want.result_block) begin
            report_mismatch($sformatf("beat %0d result_block %h, want %h", blocks_checked,
                                      out_payload.result_block, want.result_block));
          end
          if (out_payload.last_out !== want.last_out) begin
            report_mismatch($sformatf("beat %0d last_out %b, want %b", blocks_checked,
                                      out_payload.last_out, want.last_out));
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("run time limit reached with %0d results pending", expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings (all zero): field extremes and bit patterns
    send_idle_pct = 22;
    recv_idle_pct = 85;
    add_block(32'h0000_0000, 64'h0000_0000_0000_0000, 1'b0);
    add_block(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_block(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_block(32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 1'b0);
    add_block(32'h0000_0001, 64'h5555_5555_5555_5555, 1'b0);
    add_block(32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    add_block(32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
    add_block(32'hAAAA_AAAA, 64'h8000_0000_0000_0000, 1'b1);
    add_block(32'h5555_5555, 64'h0000_0000_0000_0001, 1'b0);
    // same block twice must give the same output
    add_block(32'h0000_0002, 64'h0F1E_2D3C_4B5A_6978, 1'b0);
    add_block(32'h0000_0002, 64'h0F1E_2D3C_4B5A_6978, 1'b0);
    queue_traffic(230);
    drain_pipe();

    // all-ones key and nonce
    load_settings('1, '1, '1, '1, '1, 1'b0);
    add_block(32'h0000_0000, 64'h0000_0000_0000_0000, 1'b0);
    add_block(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_block(32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1);
    add_block(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_traffic(200);
    drain_pipe();

    // swap idle roles, random settings
    send_idle_pct = 85;
    recv_idle_pct = 22;
    load_settings($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
    queue_traffic(250);
    drain_pipe();

    // random settings plus writes to unused slots; long receiver hold-off
    load_settings($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
    hold_go = 1'b1;
    queue_traffic(450);
    drain_pipe();

    // no idling; random key with zero nonce
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings($urandom, $urandom, $urandom, $urandom, 64'h0, 1'b0);
    queue_traffic(300);
    drain_pipe();

    // catch any stray late beats
    repeat (PIPE_LATENCY + 16) @(posedge clk);

    $display("Ran %0d blocks (%0d checked) over reset values and %0d key/nonce loads,",
             blocks_sent, blocks_checked, settings_loaded);
    $display("with input held off by back-pressure on %0d cycles; %0d mismatches.",
             stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> tea_ctr_block_cipher.f
hdl/teactr_pkg.sv
hdl/teactr_round.sv
hdl/tea_ctr_block_cipher.sv
sim/tea_ctr_block_cipher_tb.sv
